@@ sv/pidc_pkg.sv @@
// Shared types, widths and register codes of the clamped PID controller.
`timescale 1ns / 1ps

package pidc_pkg;

    // Fixed field widths.
    localparam int GAIN_W = 32;
    localparam int DT_W = 16;
    localparam int DT_FRAC = 12;

    // Default parameter values.
    localparam int MEAS_WIDTH_DEF = 16;
    localparam int GAIN_FRAC_BITS_DEF = 16;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_PROP = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_INTEG = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_DERIV = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_LOWER = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_UPPER = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_ON_MEAS = 3'd5;

    // Register reset values.
    localparam logic signed [GAIN_W-1:0] OUT_LOWER_RST = -32'sd32768;
    localparam logic signed [GAIN_W-1:0] OUT_UPPER_RST = 32'sd32767;

    typedef struct packed {
        logic signed [GAIN_W-1:0] gain_prop;
        logic signed [GAIN_W-1:0] gain_integ;
        logic signed [GAIN_W-1:0] gain_deriv;
        logic signed [GAIN_W-1:0] out_lower;
        logic signed [GAIN_W-1:0] out_upper;
        logic                     deriv_on_meas;
    } t_cfg;

    // Handshake from the top level into the core.
    typedef struct packed {
        logic start;
        logic res_ready;
    } t_core_ctl;

    // Status from the core back to the top level.
    typedef struct packed {
        logic idle;
        logic res_valid;
    } t_core_stat;

endpackage

@@ sv/pid_controller_clamped.sv @@
// Top level of the clamped PID controller: registers, handshakes and output word.
`timescale 1ns / 1ps

// Channel  Handshake                  Payload
// in       i_in_valid / o_in_ready    i_setpoint, i_measurement, i_step_time
// out      o_out_valid / i_out_ready  o_drive
// cfg      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One input word occupies the core until its result leaves the core for the
// output register; the radix-4 divider that forms the derivative is the longest step.
// With a zero step time the divider is skipped.
// Reset is synchronous and active low; it restores the register defaults and
// clears the integral and the previous measurement and error.
// A finished word waits in the output register, so the core takes the next
// input word while the sink stalls; a second result waits in the core.

module pid_controller_clamped #(
    parameter int MEAS_WIDTH = pidc_pkg::MEAS_WIDTH_DEF,
    parameter int GAIN_FRAC_BITS = pidc_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [MEAS_WIDTH-1:0]        i_setpoint,
    input  logic signed [MEAS_WIDTH-1:0]        i_measurement,
    input  logic [pidc_pkg::DT_W-1:0]           i_step_time,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [pidc_pkg::GAIN_W-1:0]  o_drive,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [pidc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [pidc_pkg::GAIN_W-1:0]         i_cfg_data
);

    pidc_pkg::t_cfg                      r_cfg;
    pidc_pkg::t_core_ctl                 w_ctl;
    pidc_pkg::t_core_stat                w_stat;
    logic signed [pidc_pkg::GAIN_W-1:0]  w_res_drive;
    logic                                r_out_valid;
    logic signed [pidc_pkg::GAIN_W-1:0]  r_drive;

    // Configuration words are always taken; writes to unused indexes drop out.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_prop     <= '0;
            r_cfg.gain_integ    <= '0;
            r_cfg.gain_deriv    <= '0;
            r_cfg.out_lower     <= pidc_pkg::OUT_LOWER_RST;
            r_cfg.out_upper     <= pidc_pkg::OUT_UPPER_RST;
            r_cfg.deriv_on_meas <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                pidc_pkg::CFG_GAIN_PROP:     r_cfg.gain_prop     <= $signed(i_cfg_data);
                pidc_pkg::CFG_GAIN_INTEG:    r_cfg.gain_integ    <= $signed(i_cfg_data);
                pidc_pkg::CFG_GAIN_DERIV:    r_cfg.gain_deriv    <= $signed(i_cfg_data);
                pidc_pkg::CFG_OUT_LOWER:     r_cfg.out_lower     <= $signed(i_cfg_data);
                pidc_pkg::CFG_OUT_UPPER:     r_cfg.out_upper     <= $signed(i_cfg_data);
                pidc_pkg::CFG_DERIV_ON_MEAS: r_cfg.deriv_on_meas <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // The core takes a word only while its sequencer is idle.
    assign o_in_ready      = w_stat.idle;
    assign w_ctl.start     = i_in_valid && w_stat.idle;
    assign w_ctl.res_ready = !r_out_valid || i_out_ready;

    pidc_core #(
        .MEAS_WIDTH     (MEAS_WIDTH),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_ctl         (w_ctl),
        .i_setpoint    (i_setpoint),
        .i_measurement (i_measurement),
        .i_step_time   (i_step_time),
        .o_stat        (w_stat),
        .o_drive       (w_res_drive)
    );

    // Output register: loads when the core offers a result and the slot is
    // free or being emptied in the same cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_stat.res_valid && w_ctl.res_ready) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_stat.res_valid && w_ctl.res_ready) begin
            r_drive <= w_res_drive;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_drive     = r_drive;

`ifndef SYNTHESIS
    // An accepted word keeps the core busy in the following cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("core idle right after accepting a word");

    // A result on offer means the core is not idle.
    a_result_not_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.res_valid |-> !w_stat.idle)
        else $error("core idle while offering a result");

    // A result blocked by a full, stalled output register stays on offer.
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_stat.res_valid && r_out_valid && !i_out_ready) |=> w_stat.res_valid)
        else $error("result dropped while output register was stalled");
`endif

endmodule

@@ sv/pidc_mul.sv @@
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps

module pidc_mul #(
    parameter int A_W = 49,
    parameter int B_W = 18
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [A_W-1:0]    i_a,
    input  logic signed [B_W-1:0]    i_b,
    output logic signed [A_W+B_W-1:0] o_p
);

    logic signed [A_W+B_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= (A_W+B_W)'(i_a) * (A_W+B_W)'(i_b);
        end
    end

    assign o_p = r_p;

endmodule

@@ sv/pidc_div.sv @@
// Unsigned restoring divider that retires two quotient bits per cycle.
`timescale 1ns / 1ps

module pidc_div #(
    parameter int DVD_W = 62,
    parameter int DSR_W = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DSR_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quotient
);

    localparam int STEPS = DVD_W / 2;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0] r_quo;
    logic [DSR_W-1:0] r_rem;
    logic [DSR_W-1:0] r_dsr;
    logic [DVD_W-1:0] n_quo;
    logic [DSR_W-1:0] n_rem;

    // Two dependent compare-and-subtract steps on the narrow remainder.
    always_comb begin
        logic [DSR_W:0] sh;
        logic           ge;
        n_quo = r_quo;
        n_rem = r_rem;
        for (int k = 0; k < 2; k++) begin
            sh = {n_rem, n_quo[DVD_W-1]};
            ge = (sh >= {1'b0, r_dsr});
            n_quo = {n_quo[DVD_W-2:0], ge};
            n_rem = ge ? DSR_W'(sh - {1'b0, r_dsr}) : sh[DSR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

@@ sv/pidc_core.sv @@
// Sequencer, controller state and shared arithmetic of the PID controller.
`timescale 1ns / 1ps

module pidc_core #(
    parameter int MEAS_WIDTH = pidc_pkg::MEAS_WIDTH_DEF,
    parameter int GAIN_FRAC_BITS = pidc_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  pidc_pkg::t_cfg                       i_cfg,
    input  pidc_pkg::t_core_ctl                  i_ctl,
    input  logic signed [MEAS_WIDTH-1:0]         i_setpoint,
    input  logic signed [MEAS_WIDTH-1:0]         i_measurement,
    input  logic [pidc_pkg::DT_W-1:0]            i_step_time,
    output pidc_pkg::t_core_stat                 o_stat,
    output logic signed [pidc_pkg::GAIN_W-1:0]   o_drive
);

    localparam int GW = pidc_pkg::GAIN_W;
    localparam int TW = pidc_pkg::DT_W;
    localparam int TF = pidc_pkg::DT_FRAC;
    localparam int EW = MEAS_WIDTH + 1;
    localparam int DW = MEAS_WIDTH + 2;
    localparam int AW = GW + EW;
    localparam int BW = (DW > TW + 1) ? DW : TW + 1;
    localparam int MPW = AW + BW;
    localparam int INCW = MPW - TF;
    localparam int IW = GW + GAIN_FRAC_BITS;
    localparam int ISW = ((IW > INCW) ? IW : INCW) + 1;
    localparam int PW = GW + DW;
    localparam int UDW = PW - 1 + TF;
    localparam int DVW = UDW + (UDW % 2);
    localparam int DRW = DVW + 1;
    localparam int SW0 = (AW > IW) ? AW : IW;
    localparam int SW = ((DRW > SW0) ? DRW : SW0) + 2;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_MI   = 4'd1;
    localparam logic [3:0] ST_MT   = 4'd2;
    localparam logic [3:0] ST_INT  = 4'd3;
    localparam logic [3:0] ST_MP   = 4'd4;
    localparam logic [3:0] ST_DIV  = 4'd5;
    localparam logic [3:0] ST_SUM1 = 4'd6;
    localparam logic [3:0] ST_SUM2 = 4'd7;

    logic [3:0]                 r_state;
    logic [3:0]                 n_state;
    logic signed [IW-1:0]       r_integ;
    logic signed [MEAS_WIDTH-1:0] r_prev_meas;
    logic signed [EW-1:0]       r_prev_err;
    logic signed [EW-1:0]       r_err;
    logic signed [DW-1:0]       r_diff;
    logic [TW-1:0]              r_dt;
    logic                       r_dneg;
    logic signed [SW-1:0]       r_sum;

    logic signed [EW-1:0]       w_err;
    logic signed [DW-1:0]       w_diff;
    logic                       w_dt_zero;
    logic                       w_mul_en;
    logic signed [AW-1:0]       w_mul_a;
    logic signed [BW-1:0]       w_mul_b;
    logic signed [MPW-1:0]      w_prod;
    logic signed [INCW-1:0]     w_incr;
    logic signed [ISW-1:0]      w_isum;
    logic signed [ISW-1:0]      w_ihi;
    logic signed [ISW-1:0]      w_ilo;
    logic signed [IW-1:0]       w_integ;
    logic signed [PW-1:0]       w_pd;
    logic                       w_pneg;
    logic [PW-2:0]              w_pmag;
    logic [DVW-1:0]             w_dividend;
    logic                       w_div_start;
    logic                       w_div_done;
    logic [DVW-1:0]             w_quo;
    logic signed [DRW-1:0]      w_deriv;
    logic signed [SW-1:0]       w_tot;
    logic signed [SW-1:0]       w_shi;
    logic signed [SW-1:0]       w_slo;
    logic signed [SW-1:0]       w_clamped;

    assign w_err = EW'(i_setpoint) - EW'(i_measurement);
    assign w_diff = i_cfg.deriv_on_meas ? (DW'(r_prev_meas) - DW'(i_measurement))
                                        : (DW'(w_err) - DW'(r_prev_err));
    assign w_dt_zero = (r_dt == '0);

    // Operand selection for the shared multiplier.
    always_comb begin
        w_mul_en = 1'b1;
        w_mul_a  = '0;
        w_mul_b  = '0;
        unique case (r_state)
            ST_MI: begin
                w_mul_a = AW'(i_cfg.gain_integ);
                w_mul_b = BW'(r_err);
            end
            ST_MT: begin
                w_mul_a = $signed(w_prod[AW-1:0]);
                w_mul_b = BW'($signed({1'b0, r_dt}));
            end
            ST_INT: begin
                w_mul_a = AW'(i_cfg.gain_deriv);
                w_mul_b = BW'(r_diff);
            end
            ST_MP: begin
                w_mul_a = AW'(i_cfg.gain_prop);
                w_mul_b = BW'(r_err);
            end
            default: begin
                w_mul_en = 1'b0;
            end
        endcase
    end

    pidc_mul #(
        .A_W (AW),
        .B_W (BW)
    ) u_mul (
        .i_clk (i_clk),
        .i_en  (w_mul_en),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_prod)
    );

    // Integral increment with floor, then the clamp to the scaled limits.
    assign w_incr = INCW'(w_prod >>> TF);
    assign w_isum = ISW'(r_integ) + (w_dt_zero ? '0 : ISW'(w_incr));
    assign w_ihi  = ISW'(i_cfg.out_upper) <<< GAIN_FRAC_BITS;
    assign w_ilo  = ISW'(i_cfg.out_lower) <<< GAIN_FRAC_BITS;

    always_comb begin
        priority if (w_isum > w_ihi) begin
            w_integ = IW'(w_ihi);
        end else if (w_isum < w_ilo) begin
            w_integ = IW'(w_ilo);
        end else begin
            w_integ = IW'(w_isum);
        end
    end

    // Floor division of a negative dividend runs on its complement.
    assign w_pd       = $signed(w_prod[PW-1:0]);
    assign w_pneg     = w_pd[PW-1];
    assign w_pmag     = w_pneg ? ~w_pd[PW-2:0] : w_pd[PW-2:0];
    assign w_dividend = DVW'({w_pmag, {TF{w_pneg}}});
    assign w_div_start = (r_state == ST_MP) && !w_dt_zero;

    pidc_div #(
        .DVD_W (DVW),
        .DSR_W (TW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (r_dt),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    always_comb begin
        if (w_dt_zero) begin
            w_deriv = '0;
        end else if (r_dneg) begin
            w_deriv = ~$signed({1'b0, w_quo});
        end else begin
            w_deriv = $signed({1'b0, w_quo});
        end
    end

    // Final sum, clamp and floor shift back to integer units.
    assign w_tot = r_sum + SW'(w_deriv);
    assign w_shi = SW'(i_cfg.out_upper) <<< GAIN_FRAC_BITS;
    assign w_slo = SW'(i_cfg.out_lower) <<< GAIN_FRAC_BITS;

    always_comb begin
        priority if (w_tot > w_shi) begin
            w_clamped = w_shi;
        end else if (w_tot < w_slo) begin
            w_clamped = w_slo;
        end else begin
            w_clamped = w_tot;
        end
    end

    assign o_drive = $signed(w_clamped[GAIN_FRAC_BITS+GW-1:GAIN_FRAC_BITS]);
    assign o_stat.idle      = (r_state == ST_IDLE);
    assign o_stat.res_valid = (r_state == ST_SUM2);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_ctl.start) begin
                    n_state = ST_MI;
                end
            end
            ST_MI:   n_state = ST_MT;
            ST_MT:   n_state = ST_INT;
            ST_INT:  n_state = ST_MP;
            ST_MP:   n_state = w_dt_zero ? ST_SUM1 : ST_DIV;
            ST_DIV: begin
                if (w_div_done) begin
                    n_state = ST_SUM1;
                end
            end
            ST_SUM1: n_state = ST_SUM2;
            ST_SUM2: begin
                if (i_ctl.res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_integ     <= '0;
            r_prev_meas <= '0;
            r_prev_err  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_IDLE && i_ctl.start) begin
                r_prev_meas <= i_measurement;
                r_prev_err  <= w_err;
            end
            if (r_state == ST_INT) begin
                r_integ <= w_integ;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_ctl.start) begin
            r_err  <= w_err;
            r_diff <= w_diff;
            r_dt   <= i_step_time;
        end
        if (r_state == ST_MP) begin
            r_dneg <= w_pneg;
        end
        if (r_state == ST_SUM1) begin
            r_sum <= SW'($signed(w_prod[AW-1:0])) + SW'(r_integ);
        end
    end

endmodule
